// ===== hdl/jhd_pkg.sv =====
`default_nettype none
package jhd_pkg;

  localparam int unsigned DcMaxSymbols = 16;
  localparam int unsigned AcMaxSymbols = 162;
  localparam int unsigned MaxCodeBits  = 16;
  localparam int unsigned TableSlots   = 256;
  localparam int unsigned SlotBits     = 8;
  localparam logic [17:0] CodeSat      = 18'h1FFFF;

  typedef enum logic [1:0] {
    KIND_SYMBOL = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TABLE_ID = 3'd1,
    ERR_TOO_MANY = 3'd2,
    ERR_NO_MATCH = 3'd3,
    ERR_INDEX    = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_HEADER  = 3'd2,
    PH_COUNTS  = 3'd3,
    PH_SYMBOLS = 3'd4,
    PH_SKIP    = 3'd5
  } phase_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       coded_bit;
    logic [1:0] table_select;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] symbol;
    logic [4:0] code_length;
    logic [2:0] error_code;
  } out_item_t;

  function automatic logic [8:0] limit_of(input logic [1:0] tbl);
    limit_of = tbl[1] ? 9'(AcMaxSymbols) : 9'(DcMaxSymbols);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/jpeg_huffman_table_load_and_decode.sv =====
// Channel  | Handshake                        | Payload
// in       | in_valid_i / in_ready_o          | jhd_pkg::in_item_t
// out      | out_valid_o / out_ready_i        | jhd_pkg::out_item_t
// One transaction per cycle in and one result per cycle out. Every item walks
// stage 1 (code table read) and stage 2 (symbol read, output register), and its
// result is taken from the stage-2 output register. Segment bytes write the
// tables at accept; the next coded bit gets the code restart from the stage-1
// compare by forwarding. Reset clears control state, table-entry valid
// bits and per-table symbol fill counts; unloaded entries read as zero.
// The pipeline and in_ready_o stall only while stage 2 holds a result and
// out_ready_i is low.
`default_nettype none
module jpeg_huffman_table_load_and_decode (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire jhd_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output jhd_pkg::out_item_t      out_data_o
);

  // code tables {min, max, value pointer}, index = table * 16 + length - 1
  logic [47:0] tab_mem [64];
  logic [7:0]  sym_mem [4*jhd_pkg::TableSlots];
  logic [63:0] tv_q;
  // symbols are written from slot 0 upward, so a fill count per table marks
  // the slots written since reset
  logic [3:0][jhd_pkg::SlotBits:0] fill_q;

  // decode-side registers
  logic [15:0] acc_q, acc_d;
  logic [3:0]  bits_q, bits_d;
  // parser registers
  jhd_pkg::phase_e ph_q, ph_d;
  logic [15:0] left_q, left_d;
  logic [1:0]  ltab_q, ltab_d;
  logic [3:0]  lidx_q, lidx_d;
  logic [11:0] leaves_q, leaves_d;
  logic [11:0] sidx_q, sidx_d;
  logic [17:0] rc_q, rc_d;

  // stage 1
  logic        s1_bit_q;
  logic        s1_res_q;
  jhd_pkg::out_item_t s1_bres_q;
  logic [15:0] s1_code_q;
  logic [3:0]  s1_len_q;
  logic [1:0]  s1_sel_q;
  logic        s1_tv_q;
  logic [47:0] tab_rd_q;

  // stage 2 (output)
  logic        s2_v_q;
  jhd_pkg::out_item_t s2_res_q;
  logic        s2_symok_q;
  logic [7:0]  sym_rd_q;

  logic adv, acc_in, rd_bit;

  logic        tw_en;
  logic [5:0]  tw_slot;
  logic [17:0] tw_min, tw_max;
  logic [11:0] tw_vp;
  logic        sw_en;
  logic [jhd_pkg::SlotBits+1:0] sw_addr;

  logic        bres_v;
  jhd_pkg::out_item_t bres;

  logic [18:0] mc_w, rc_w;
  logic [17:0] mc, rcn;
  logic [11:0] leaves_n;
  logic [15:0] total, left_n;
  logic [3:0]  cls, idn;
  logic [2:0]  err_c;

  logic [17:0] mn, mx;
  logic [11:0] vp;
  logic        s1_match, s1_restart, idx_ok;
  logic signed [18:0] idx;
  logic [jhd_pkg::SlotBits+1:0] sym_raddr;
  logic        s1_rv, s1_symok;
  jhd_pkg::out_item_t s1_res;

  logic [3:0]  len0;
  logic [15:0] code0, code_in;
  logic [5:0]  rslot;

  assign adv        = !s2_v_q || out_ready_i;
  assign in_ready_o = adv;
  assign acc_in     = in_valid_i && adv;
  assign rd_bit     = acc_in && in_data_i.op;

  always_comb begin
    ph_d = ph_q; left_d = left_q; ltab_d = ltab_q; lidx_d = lidx_q;
    leaves_d = leaves_q; sidx_d = sidx_q; rc_d = rc_q;
    tw_en = 1'b0; tw_slot = {ltab_q, lidx_q};
    sw_en = 1'b0; sw_addr = {ltab_q, sidx_q[jhd_pkg::SlotBits-1:0]};
    bres_v = 1'b0; bres = '0;
    mc_w = {rc_q, 1'b0};
    mc   = (mc_w > 19'(jhd_pkg::CodeSat)) ? jhd_pkg::CodeSat : mc_w[17:0];
    rc_w = {1'b0, mc} + 19'(in_data_i.data_byte);
    rcn  = (rc_w > 19'(jhd_pkg::CodeSat)) ? jhd_pkg::CodeSat : rc_w[17:0];
    tw_min = mc;
    tw_max = (in_data_i.data_byte != 8'd0) ? rcn - 18'd1 : 18'h3FFFF;
    tw_vp  = leaves_q;
    leaves_n = leaves_q + 12'(in_data_i.data_byte);
    total = {left_q[15:8], in_data_i.data_byte};
    left_n = left_q - 16'd1;
    cls = in_data_i.data_byte[7:4];
    idn = in_data_i.data_byte[3:0];
    err_c = jhd_pkg::ERR_NONE;
    if (acc_in && !in_data_i.op) begin
      case (ph_q)
        jhd_pkg::PH_LEN_HI: begin
          left_d = {in_data_i.data_byte, 8'd0};
          ph_d = jhd_pkg::PH_LEN_LO;
        end
        jhd_pkg::PH_LEN_LO: begin
          if (total <= 16'd2) begin
            left_d = '0; ph_d = jhd_pkg::PH_LEN_HI;
            bres_v = 1'b1; bres.kind = jhd_pkg::KIND_DONE;
          end else begin
            left_d = total - 16'd2; ph_d = jhd_pkg::PH_HEADER;
          end
        end
        default: begin
          case (ph_q)
            jhd_pkg::PH_HEADER: begin
              if (cls > 4'd1 || idn > 4'd1) begin
                err_c = jhd_pkg::ERR_TABLE_ID; ph_d = jhd_pkg::PH_SKIP;
              end else begin
                ltab_d = {cls[0], idn[0]}; lidx_d = '0; leaves_d = '0;
                rc_d = '0; sidx_d = '0; ph_d = jhd_pkg::PH_COUNTS;
              end
            end
            jhd_pkg::PH_COUNTS: begin
              tw_en = 1'b1;
              rc_d = rcn;
              leaves_d = leaves_n;
              if (lidx_q == 4'd15) begin
                lidx_d = '0;
                if (leaves_n > 12'(jhd_pkg::limit_of(ltab_q)))
                  err_c = jhd_pkg::ERR_TOO_MANY;
                sidx_d = '0;
                ph_d = (leaves_n == 12'd0) ? jhd_pkg::PH_HEADER : jhd_pkg::PH_SYMBOLS;
              end else begin
                lidx_d = lidx_q + 4'd1;
              end
            end
            jhd_pkg::PH_SYMBOLS: begin
              if (sidx_q < 12'(jhd_pkg::limit_of(ltab_q)) &&
                  sidx_q < 12'(jhd_pkg::TableSlots))
                sw_en = 1'b1;
              sidx_d = sidx_q + 12'd1;
              if (sidx_q + 12'd1 >= leaves_q) ph_d = jhd_pkg::PH_HEADER;
            end
            jhd_pkg::PH_SKIP: ;
            default: ph_d = jhd_pkg::PH_SKIP;
          endcase
          left_d = left_n;
          if (err_c != jhd_pkg::ERR_NONE) begin
            bres_v = 1'b1; bres.kind = jhd_pkg::KIND_ERROR; bres.error_code = err_c;
            if (left_n == 16'd0) ph_d = jhd_pkg::PH_LEN_HI;
          end else if (left_n == 16'd0) begin
            ph_d = jhd_pkg::PH_LEN_HI;
            bres_v = 1'b1; bres.kind = jhd_pkg::KIND_DONE;
          end
        end
      endcase
    end
  end

  // stage 1: compare the code against the max code of its length
  assign mn = s1_tv_q ? tab_rd_q[47:30] : 18'd0;
  assign mx = s1_tv_q ? tab_rd_q[29:12] : 18'd0;
  assign vp = s1_tv_q ? tab_rd_q[11:0]  : 12'd0;
  assign s1_match   = $signed({3'b000, s1_code_q}) <= $signed({mx[17], mx});
  assign s1_restart = s1_match || (s1_len_q == 4'd15);
  assign idx = $signed({7'd0, vp}) + $signed({3'd0, s1_code_q}) - $signed({1'b0, mn});
  assign idx_ok = !idx[18] &&
                  (idx[17:0] < 18'(jhd_pkg::limit_of(s1_sel_q))) &&
                  (idx[17:0] < 18'(jhd_pkg::TableSlots));
  assign sym_raddr = {s1_sel_q, idx[jhd_pkg::SlotBits-1:0]};

  always_comb begin
    s1_res = s1_bres_q; s1_rv = s1_res_q; s1_symok = 1'b0;
    if (s1_bit_q) begin
      s1_res = '0;
      s1_rv = s1_restart;
      if (s1_match) begin
        if (idx_ok) begin
          s1_res.kind = jhd_pkg::KIND_SYMBOL;
          s1_res.code_length = {1'b0, s1_len_q} + 5'd1;
          s1_symok = idx[jhd_pkg::SlotBits:0] < fill_q[s1_sel_q];
        end else begin
          s1_res.kind = jhd_pkg::KIND_ERROR; s1_res.error_code = jhd_pkg::ERR_INDEX;
        end
      end else begin
        s1_res.kind = jhd_pkg::KIND_ERROR; s1_res.error_code = jhd_pkg::ERR_NO_MATCH;
      end
    end
  end

  // code state seen by the incoming bit, after the stage-1 bit resolves
  always_comb begin
    len0  = bits_q;
    code0 = acc_q;
    if (s1_bit_q) begin
      if (s1_restart) begin
        len0 = '0; code0 = '0;
      end else begin
        len0 = s1_len_q + 4'd1; code0 = s1_code_q;
      end
    end
  end

  assign code_in = {code0[14:0], in_data_i.coded_bit};
  assign rslot   = {in_data_i.table_select, len0};
  assign acc_d   = adv ? code0 : acc_q;
  assign bits_d  = adv ? len0 : bits_q;

  // a symbol read and a write of the same slot in one cycle return the old byte
  always_ff @(posedge clk_i) begin
    if (tw_en) tab_mem[tw_slot] <= {tw_min, tw_max, tw_vp};
    if (rd_bit) tab_rd_q <= tab_mem[rslot];
    if (sw_en) sym_mem[sw_addr] <= in_data_i.data_byte;
    if (adv && s1_bit_q) sym_rd_q <= sym_mem[sym_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rd_bit) begin
      s1_code_q <= code_in;
      s1_len_q  <= len0;
      s1_sel_q  <= in_data_i.table_select;
      s1_tv_q   <= tv_q[rslot];
    end
    if (adv) begin
      s1_bres_q  <= bres;
      s2_res_q   <= s1_res;
      s2_symok_q <= s1_symok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0; fill_q <= '0; acc_q <= '0; bits_q <= '0;
      ph_q <= jhd_pkg::PH_LEN_HI; left_q <= '0; ltab_q <= '0; lidx_q <= '0;
      leaves_q <= '0; sidx_q <= '0; rc_q <= '0;
      s1_bit_q <= 1'b0; s1_res_q <= 1'b0; s2_v_q <= 1'b0;
    end else begin
      if (tw_en) tv_q[tw_slot] <= 1'b1;
      if (sw_en && sidx_q[jhd_pkg::SlotBits:0] >= fill_q[ltab_q])
        fill_q[ltab_q] <= sidx_q[jhd_pkg::SlotBits:0] + 1'b1;
      acc_q <= acc_d; bits_q <= bits_d;
      ph_q <= ph_d; left_q <= left_d; ltab_q <= ltab_d; lidx_q <= lidx_d;
      leaves_q <= leaves_d; sidx_q <= sidx_d; rc_q <= rc_d;
      if (adv) begin
        s1_bit_q <= rd_bit;
        s1_res_q <= bres_v;
        s2_v_q   <= s1_rv;
      end
    end
  end

  assign out_valid_o = s2_v_q;

  always_comb begin
    out_data_o = s2_res_q;
    if (s2_symok_q) out_data_o.symbol = sym_rd_q;
  end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  jhd_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  jhd_pkg::out_item_t out_data_o;
  bit                 failed = 1'b0;

  always #2 clk_i = ~clk_i;

  jpeg_huffman_table_load_and_decode dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  class huff_scoreboard;
    logic [17:0] min_code[64];
    logic [17:0] max_code[64];
    logic [11:0] val_ptr[64];
    logic [7:0]  sym_mem[4*jhd_pkg::TableSlots];
    logic [15:0] acc;
    logic [4:0]  nbits;
    jhd_pkg::phase_e phase;
    logic [15:0] bytes_left;
    logic [1:0]  cur_tbl;
    logic [3:0]  len_idx;
    logic [11:0] leaves;
    logic [11:0] sym_idx;
    logic [17:0] run_code;
    jhd_pkg::out_item_t pending[$];

    function new();
      foreach (min_code[i]) begin
        min_code[i] = '0;
        max_code[i] = '0;
        val_ptr[i] = '0;
      end
      foreach (sym_mem[i]) sym_mem[i] = '0;
      acc = '0;
      nbits = '0;
      phase = jhd_pkg::PH_LEN_HI;
      bytes_left = '0;
      cur_tbl = '0;
      len_idx = '0;
      leaves = '0;
      sym_idx = '0;
      run_code = '0;
    endfunction

    function int unsigned lim(logic [1:0] t);
      return t[1] ? jhd_pkg::AcMaxSymbols : jhd_pkg::DcMaxSymbols;
    endfunction

    function void push(jhd_pkg::kind_e k, logic [7:0] s, logic [4:0] l, jhd_pkg::err_e e);
      jhd_pkg::out_item_t r;
      r.kind = k;
      r.symbol = s;
      r.code_length = l;
      r.error_code = e;
      pending.push_back(r);
    endfunction

    function void seg_byte(logic [7:0] b);
      jhd_pkg::err_e e;
      int unsigned slot, mc, rc, total;
      e = jhd_pkg::ERR_NONE;
      if (phase == jhd_pkg::PH_LEN_HI) begin
        bytes_left = {b, 8'h00};
        phase = jhd_pkg::PH_LEN_LO;
        return;
      end
      if (phase == jhd_pkg::PH_LEN_LO) begin
        total = {bytes_left[15:8], b};
        if (total <= 2) begin
          bytes_left = '0;
          phase = jhd_pkg::PH_LEN_HI;
          push(jhd_pkg::KIND_DONE, 0, 0, jhd_pkg::ERR_NONE);
        end else begin
          bytes_left = 16'(total - 2);
          phase = jhd_pkg::PH_HEADER;
        end
        return;
      end
      case (phase)
        jhd_pkg::PH_HEADER: begin
          if (b[7:4] > 1 || b[3:0] > 1) begin
            e = jhd_pkg::ERR_TABLE_ID;
            phase = jhd_pkg::PH_SKIP;
          end else begin
            cur_tbl = {b[4], b[0]};
            len_idx = '0;
            leaves = '0;
            run_code = '0;
            sym_idx = '0;
            phase = jhd_pkg::PH_COUNTS;
          end
        end
        jhd_pkg::PH_COUNTS: begin
          slot = cur_tbl * 16 + len_idx;
          val_ptr[slot] = leaves;
          mc = run_code << 1;
          if (mc > jhd_pkg::CodeSat) mc = jhd_pkg::CodeSat;
          min_code[slot] = 18'(mc);
          rc = mc + b;
          if (rc > jhd_pkg::CodeSat) rc = jhd_pkg::CodeSat;
          run_code = 18'(rc);
          max_code[slot] = (b != 0) ? 18'(rc - 1) : 18'h3FFFF;
          leaves = 12'(leaves + b);
          if (len_idx == 15) begin
            len_idx = '0;
            if (leaves > lim(cur_tbl)) e = jhd_pkg::ERR_TOO_MANY;
            sym_idx = '0;
            phase = (leaves == 0) ? jhd_pkg::PH_HEADER : jhd_pkg::PH_SYMBOLS;
          end else len_idx = 4'(len_idx + 1);
        end
        jhd_pkg::PH_SYMBOLS: begin
          if (sym_idx < lim(cur_tbl) && sym_idx < jhd_pkg::TableSlots)
            sym_mem[cur_tbl * jhd_pkg::TableSlots + sym_idx] = b;
          sym_idx = 12'(sym_idx + 1);
          if (sym_idx >= leaves) phase = jhd_pkg::PH_HEADER;
        end
        default: ;
      endcase
      bytes_left = 16'(bytes_left - 1);
      if (bytes_left == 0) phase = jhd_pkg::PH_LEN_HI;
      if (e != jhd_pkg::ERR_NONE) push(jhd_pkg::KIND_ERROR, 0, 0, e);
      else if (bytes_left == 0) push(jhd_pkg::KIND_DONE, 0, 0, jhd_pkg::ERR_NONE);
    endfunction

    function void code_bit(logic bt, logic [1:0] sel);
      int unsigned len, slot;
      longint mx, idx;
      len = nbits[3:0];
      slot = sel * 16 + len;
      acc = {acc[14:0], bt};
      mx = max_code[slot][17] ? longint'(max_code[slot]) - 64'h40000
                              : longint'(max_code[slot]);
      if (longint'(acc) <= mx) begin
        idx = longint'(val_ptr[slot]) + longint'(acc) - longint'(min_code[slot]);
        acc = '0;
        nbits = '0;
        if (idx < 0 || idx >= lim(sel) || idx >= jhd_pkg::TableSlots)
          push(jhd_pkg::KIND_ERROR, 0, 0, jhd_pkg::ERR_INDEX);
        else push(jhd_pkg::KIND_SYMBOL, sym_mem[sel * jhd_pkg::TableSlots + idx],
                  5'(len + 1), jhd_pkg::ERR_NONE);
        return;
      end
      nbits = 5'(len + 1);
      if (nbits >= jhd_pkg::MaxCodeBits) begin
        acc = '0;
        nbits = '0;
        push(jhd_pkg::KIND_ERROR, 0, 0, jhd_pkg::ERR_NO_MATCH);
      end
    endfunction

    function void note_input(jhd_pkg::in_item_t it);
      if (it.op) code_bit(it.coded_bit, it.table_select);
      else seg_byte(it.data_byte);
    endfunction

    function bit check_result(jhd_pkg::out_item_t got);
      jhd_pkg::out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        return 1'b0;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        return 1'b0;
      end
      return 1'b1;
    endfunction
  endclass

  huff_scoreboard sb = new();

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // valid stays high after the accepting edge; the next call either drops it
  // for a gap or puts the next transaction on at once
  task automatic send(jhd_pkg::in_item_t it);
    int unsigned g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    jhd_pkg::in_item_t it;
    it = '0;
    it.data_byte = b;
    it.coded_bit = 1'($urandom);
    it.table_select = 2'($urandom);
    send(it);
  endtask

  task automatic send_bit(logic bt, logic [1:0] sel);
    jhd_pkg::in_item_t it;
    it = '0;
    it.op = 1'b1;
    it.coded_bit = bt;
    it.table_select = sel;
    it.data_byte = 8'($urandom);
    send(it);
  endtask

  // well-formed DHT segment with random counts, optionally over the limit
  task automatic send_table(input logic [1:0] t, input bit overfill,
                            output int unsigned sent);
    logic [7:0] cnt[16];
    int unsigned total, room, c, len;
    total = 0;
    room = overfill ? 200 : (t[1] ? jhd_pkg::AcMaxSymbols : jhd_pkg::DcMaxSymbols);
    for (int i = 0; i < 16; i++) begin
      c = (i < 2 && total < room) ? $urandom_range(0, 2) : 0;
      if (i >= 2 && total < room) c = $urandom_range(0, (room - total) > 6 ? 6 : room - total);
      cnt[i] = 8'(c);
      total += c;
    end
    if (total == 0) begin
      cnt[1] = 1;
      total = 1;
    end
    len = 2 + 1 + 16 + total;
    send_byte(8'(len >> 8));
    send_byte(8'(len));
    send_byte({3'b000, t[1], 3'b000, t[0]});
    for (int i = 0; i < 16; i++) send_byte(cnt[i]);
    for (int i = 0; i < total; i++) send_byte(8'($urandom));
    sent = len;
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1)) send_byte(8'($urandom));
    else send_bit(1'($urandom), 2'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      if (!sb.check_result(out_data_o)) failed <= 1'b1;
    out_ready_i <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 19) == 0);
  end

  initial begin
    int unsigned n;
    int unsigned k;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: decode before any load, short segment, bad ids, all tables
    send_bit(1'b0, 2'd0);
    send_bit(1'b1, 2'd3);
    send_byte(8'h00);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'h04);
    send_byte(8'h22);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_table(2'd0, 1'b0, k);
    send_table(2'd1, 1'b1, k);
    send_table(2'd2, 1'b0, k);
    send_table(2'd3, 1'b1, k);
    for (int i = 0; i < 17; i++) send_bit(1'b1, 2'd0);
    // random phase
    n = 0;
    while (n < 900) begin
      if ($urandom_range(0, 9) < 2) begin
        send_table(2'($urandom), $urandom_range(0, 7) == 0, k);
        n += k;
      end else if ($urandom_range(0, 19) == 0) begin
        send_noise();
        n++;
      end else begin
        repeat ($urandom_range(1, 20)) begin
          send_bit(1'($urandom), $urandom_range(0, 3) == 0 ? 2'($urandom) : 2'd2);
          n++;
        end
      end
    end
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed && sb.pending.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/jhd_pkg.sv
hdl/jpeg_huffman_table_load_and_decode.sv
tb/tb.sv
